// ===== hdl/tdc_pkg.sv =====
// Shared types, register indexes and reset constants of the tone divider control block.
package tdc_pkg;

  localparam int unsigned ADC_BITS_DEF = 10;

  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;

  localparam logic [15:0] MIN_FREQ_RST       = 16'd50;
  localparam logic [15:0] MAX_FREQ_RST       = 16'd1000;
  localparam logic [7:0]  STEP_SIZE_RST      = 8'd10;
  localparam logic [23:0] TIMER_CLOCK_RST    = 24'd62500;
  localparam logic [9:0]  ADC_FULL_SCALE_RST = 10'd1023;
  localparam logic [15:0] TONE_FREQ_RST      = 16'd250;

  localparam int unsigned CFG_DATA_W  = 24;
  localparam int unsigned CFG_INDEX_W = 3;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_MIN_FREQ       = 3'd0,
    REG_MAX_FREQ       = 3'd1,
    REG_STEP_SIZE      = 3'd2,
    REG_TIMER_CLOCK    = 3'd3,
    REG_ADC_FULL_SCALE = 3'd4
  } tdc_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_LOAD_Q,
    ST_QUO,
    ST_SUM,
    ST_LOAD_D,
    ST_DIV,
    ST_DONE
  } tdc_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic mul;
    logic div_load;
    logic div_sel_timer;
    logic div_step;
    logic sum;
    logic load_out;
  } tdc_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic need_mul;
  } tdc_status_t;

endpackage

// ===== hdl/tdc_ctrl.sv =====
// Controller state machine that sequences capture, multiply, divisions and result hand-off.
module tdc_ctrl
  import tdc_pkg::*;
#(
  parameter int unsigned DIV_W = 26
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  output logic        out_valid,
  input  logic        out_stall,
  input  tdc_status_t status,
  output tdc_cmd_t    cmd
);

  localparam int unsigned CNT_W = $clog2(DIV_W);

  tdc_state_t       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             last_step;

  assign last_step = (cnt_r == CNT_W'(DIV_W - 1));
  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd           = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = status.need_mul ? ST_MUL : ST_LOAD_D;
        end
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_LOAD_Q;
      end
      ST_LOAD_Q: begin
        cmd.div_load = 1'b1;
        cnt_nxt      = '0;
        state_nxt    = ST_QUO;
      end
      ST_QUO: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (last_step) begin
          state_nxt = ST_SUM;
        end
      end
      ST_SUM: begin
        cmd.sum   = 1'b1;
        state_nxt = ST_LOAD_D;
      end
      ST_LOAD_D: begin
        cmd.div_load      = 1'b1;
        cmd.div_sel_timer = 1'b1;
        cnt_nxt           = '0;
        state_nxt         = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (last_step) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        // The result register is free once its previous transaction has gone.
        if (!out_valid_r || !out_stall) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== hdl/tdc_dp.sv =====
// Datapath: configuration registers, tone frequency, multiplier, shared divider and result registers.
module tdc_dp
  import tdc_pkg::*;
#(
  parameter int unsigned ADC_BITS = ADC_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                   in_action,
  input  logic [7:0]             in_received_byte,
  input  logic [ADC_BITS-1:0]    in_adc_sample,
  input  tdc_cmd_t               cmd,
  output tdc_status_t            status,
  output logic [15:0]            out_frequency,
  output logic [15:0]            out_divider,
  output logic                   out_echo_valid,
  output logic [7:0]             out_echo_byte
);

  // Only the low ten bits of a reading are ever used.
  localparam int unsigned SMP_W  = (ADC_BITS < 10) ? ADC_BITS : 10;
  localparam int unsigned PROD_W = SMP_W + 18;
  localparam int unsigned DIV_W  = (SMP_W + 16 > 24) ? SMP_W + 16 : 24;
  localparam int unsigned SUM_W  = DIV_W + 2;

  logic [15:0]        min_freq_r, max_freq_r, tone_r;
  logic [7:0]         step_size_r;
  logic [23:0]        timer_clock_r;
  logic [9:0]         full_scale_r;
  logic [SMP_W-1:0]   sample_r;
  logic               echo_r;
  logic [7:0]         echo_byte_r;
  logic signed [PROD_W-1:0] prod_r;
  logic               neg_r;
  logic [15:0]        rem_r;
  logic [DIV_W-1:0]   quo_r;
  logic [15:0]        dvs_r;
  logic [15:0]        out_freq_r, out_div_r;
  logic               out_echo_r;
  logic [7:0]         out_echo_byte_r;

  logic               is_plus, is_minus;
  logic signed [17:0] step_s;
  logic [15:0]        step_sat, byte_freq;
  logic signed [16:0] diff_s;
  logic [DIV_W-1:0]   prod_mag;
  logic [16:0]        rem_sh, rem_sub;
  logic               q_bit;
  logic signed [SUM_W-1:0] quo_s, sum_s;
  logic [15:0]        sum_sat;
  logic [DIV_W-1:0]   quo_m1;
  logic [15:0]        div_val;

  assign status.need_mul = in_action && (full_scale_r != '0);

  // Terminal byte path: step, saturate to 16 bits, then clamp to max and min.
  always_comb begin
    is_plus  = (in_received_byte == CHAR_PLUS);
    is_minus = (in_received_byte == CHAR_MINUS);
    step_s   = $signed({2'b00, tone_r});
    if (is_plus) begin
      step_s = $signed({2'b00, tone_r}) + $signed({10'd0, step_size_r});
    end else if (is_minus) begin
      step_s = $signed({2'b00, tone_r}) - $signed({10'd0, step_size_r});
    end
    if (step_s < 0) begin
      step_sat = 16'd0;
    end else if (step_s > 18'sd65535) begin
      step_sat = 16'hFFFF;
    end else begin
      step_sat = step_s[15:0];
    end
    byte_freq = step_sat;
    if (byte_freq > max_freq_r) begin
      byte_freq = max_freq_r;
    end
    if (byte_freq < min_freq_r) begin
      byte_freq = min_freq_r;
    end
  end

  assign diff_s   = $signed({1'b0, max_freq_r}) - $signed({1'b0, min_freq_r});
  assign prod_mag = prod_r[PROD_W-1] ? DIV_W'(-prod_r) : DIV_W'(prod_r);

  // One restoring division step.
  always_comb begin
    rem_sh  = {rem_r, quo_r[DIV_W-1]};
    rem_sub = rem_sh - {1'b0, dvs_r};
    q_bit   = (rem_sh >= {1'b0, dvs_r});
  end

  // The quotient truncates towards zero, so the sign is applied to its magnitude.
  always_comb begin
    quo_s = neg_r ? -$signed({2'b00, quo_r}) : $signed({2'b00, quo_r});
    sum_s = $signed({{(SUM_W-16){1'b0}}, min_freq_r}) + quo_s;
    if (sum_s < 0) begin
      sum_sat = 16'd0;
    end else if (sum_s > $signed(SUM_W'(65535))) begin
      sum_sat = 16'hFFFF;
    end else begin
      sum_sat = sum_s[15:0];
    end
  end

  always_comb begin
    quo_m1 = quo_r - 1'b1;
    if (tone_r == '0) begin
      div_val = 16'hFFFF;
    end else if (quo_r == '0) begin
      div_val = 16'd0;
    end else if (|quo_m1[DIV_W-1:16]) begin
      div_val = 16'hFFFF;
    end else begin
      div_val = quo_m1[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_freq_r    <= MIN_FREQ_RST;
      max_freq_r    <= MAX_FREQ_RST;
      step_size_r   <= STEP_SIZE_RST;
      timer_clock_r <= TIMER_CLOCK_RST;
      full_scale_r  <= ADC_FULL_SCALE_RST;
      tone_r        <= TONE_FREQ_RST;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_MIN_FREQ:       min_freq_r    <= cfg_wdata[15:0];
          REG_MAX_FREQ:       max_freq_r    <= cfg_wdata[15:0];
          REG_STEP_SIZE:      step_size_r   <= cfg_wdata[7:0];
          REG_TIMER_CLOCK:    timer_clock_r <= cfg_wdata[23:0];
          REG_ADC_FULL_SCALE: full_scale_r  <= cfg_wdata[9:0];
          default: begin
          end
        endcase
      end
      if (cmd.capture) begin
        if (!in_action) begin
          tone_r <= byte_freq;
        end else if (full_scale_r == '0) begin
          tone_r <= max_freq_r;
        end
      end else if (cmd.sum) begin
        tone_r <= sum_sat;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      sample_r    <= in_adc_sample[SMP_W-1:0];
      echo_r      <= !in_action && (is_plus || is_minus);
      echo_byte_r <= (!in_action && (is_plus || is_minus)) ? in_received_byte : 8'd0;
    end
    if (cmd.mul) begin
      prod_r <= PROD_W'($signed({1'b0, sample_r})) * PROD_W'(diff_s);
    end
    if (cmd.div_load) begin
      rem_r <= '0;
      if (cmd.div_sel_timer) begin
        quo_r <= DIV_W'(timer_clock_r);
        dvs_r <= tone_r;
      end else begin
        quo_r <= prod_mag;
        dvs_r <= {6'd0, full_scale_r};
        neg_r <= prod_r[PROD_W-1];
      end
    end else if (cmd.div_step) begin
      rem_r <= q_bit ? rem_sub[15:0] : rem_sh[15:0];
      quo_r <= {quo_r[DIV_W-2:0], q_bit};
    end
    if (cmd.load_out) begin
      out_freq_r      <= tone_r;
      out_div_r       <= div_val;
      out_echo_r      <= echo_r;
      out_echo_byte_r <= echo_byte_r;
    end
  end

  assign out_frequency  = out_freq_r;
  assign out_divider    = out_div_r;
  assign out_echo_valid = out_echo_r;
  assign out_echo_byte  = out_echo_byte_r;

endmodule

// ===== hdl/tone_divider_control_core.sv =====
// Top level of the tone divider control block: controller and datapath.
// Each transaction on the input channel gives exactly one result transaction.
// Each item's processing time is set by the shared radix-2 divider, DIV_W = 26 bits
// wide for ten-bit readings, which retires one quotient bit per cycle: a sample needs
// it twice, once to scale the reading and once for the timer divider, a byte only for
// the latter; a sample with a zero full scale also needs it only for the latter. One
// item is worked on at a time; the next is accepted as soon as the previous result has
// been placed in the output register, even while that result is still stalled.
// Configuration writes take effect at once and are intended for idle.
module tone_divider_control_core
  import tdc_pkg::*;
#(
  parameter int unsigned ADC_BITS = ADC_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   in_action,
  input  logic [7:0]             in_received_byte,
  input  logic [ADC_BITS-1:0]    in_adc_sample,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [15:0]            out_frequency,
  output logic [15:0]            out_divider,
  output logic                   out_echo_valid,
  output logic [7:0]             out_echo_byte
);

  localparam int unsigned SMP_W = (ADC_BITS < 10) ? ADC_BITS : 10;
  localparam int unsigned DIV_W = (SMP_W + 16 > 24) ? SMP_W + 16 : 24;

  tdc_cmd_t    cmd;
  tdc_status_t status;

  tdc_ctrl #(
    .DIV_W(DIV_W)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .status   (status),
    .cmd      (cmd)
  );

  tdc_dp #(
    .ADC_BITS(ADC_BITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_action       (in_action),
    .in_received_byte(in_received_byte),
    .in_adc_sample   (in_adc_sample),
    .cmd             (cmd),
    .status          (status),
    .out_frequency   (out_frequency),
    .out_divider     (out_divider),
    .out_echo_valid  (out_echo_valid),
    .out_echo_byte   (out_echo_byte)
  );

endmodule

// ===== hdl/tdc_checker.sv =====
// Port-level checks of the tone divider control block and their binding to the top level.
module tdc_checker
  import tdc_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [15:0] out_frequency,
  input logic [15:0] out_divider,
  input logic        out_echo_valid,
  input logic [7:0]  out_echo_byte
);

  // A stalled result holds until its transaction completes.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_frequency) && $stable(out_divider))
    else $error("result changed while stalled");

  a_echo_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_echo_valid |-> out_echo_byte == 8'd0)
    else $error("echo byte set without echo");

  a_echo_char: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_echo_valid |-> out_echo_byte == CHAR_PLUS || out_echo_byte == CHAR_MINUS)
    else $error("echo of a character other than plus or minus");

  a_zero_freq: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frequency == 16'd0 |-> out_divider == 16'hFFFF)
    else $error("zero frequency without saturated divider");

endmodule

bind tone_divider_control_core tdc_checker u_tdc_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .out_frequency (out_frequency),
  .out_divider   (out_divider),
  .out_echo_valid(out_echo_valid),
  .out_echo_byte (out_echo_byte)
);

// ===== test/tdc_result_checker.sv =====
// Result checker for the tone divider control block: predicts every result and compares it.
`timescale 1ns / 1ps
module tdc_result_checker
  import tdc_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_we,
  input  logic [CFG_INDEX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_wdata,
  input  logic                    in_valid,
  input  logic                    in_stall,
  input  logic                    in_action,
  input  logic [7:0]              in_received_byte,
  input  logic [ADC_BITS_DEF-1:0] in_adc_sample,
  input  logic                    out_valid,
  input  logic                    out_stall,
  input  logic [15:0]             out_frequency,
  input  logic [15:0]             out_divider,
  input  logic                    out_echo_valid,
  input  logic [7:0]              out_echo_byte,
  output int                      fail_count,
  output int                      pending
);

  typedef struct packed {
    logic [15:0] freq;
    logic [15:0] div;
    logic        echo_v;
    logic [7:0]  echo_b;
  } tone_result_t;

  logic [15:0]             min_hz;
  logic [15:0]             max_hz;
  logic [7:0]              step_hz;
  logic [23:0]             timer_clk;
  logic [ADC_BITS_DEF-1:0] full_scale;
  logic [15:0]             tone_hz;

  tone_result_t expected_tones[$];
  tone_result_t got;
  tone_result_t want;
  int           mismatches = 0;

  function automatic logic [15:0] clip16(input longint v);
    if (v < 0) return 16'd0;
    if (v > 65535) return 16'hFFFF;
    return v[15:0];
  endfunction

  function automatic logic [15:0] timer_compare(input logic [15:0] f);
    logic [23:0] q;
    if (f == 16'd0) return 16'hFFFF;
    q = timer_clk / f;
    if (q == 24'd0) return 16'd0;
    q = q - 24'd1;
    return (q > 24'd65535) ? 16'hFFFF : q[15:0];
  endfunction

  // Moves the held frequency on by one transaction and returns the result it gives.
  function automatic tone_result_t advance_tone(input logic act, input logic [7:0] ch,
                                                input logic [ADC_BITS_DEF-1:0] smp);
    tone_result_t r;
    longint       f;
    longint       span;
    r.echo_v = 1'b0;
    r.echo_b = 8'd0;
    if (!act) begin
      f = longint'(tone_hz);
      if (ch == CHAR_PLUS) begin
        f = f + longint'(step_hz);
        r.echo_v = 1'b1;
        r.echo_b = ch;
      end else if (ch == CHAR_MINUS) begin
        f = f - longint'(step_hz);
        r.echo_v = 1'b1;
        r.echo_b = ch;
      end
      f = longint'(clip16(f));
      // The lower limit is applied last, so it wins when the limits cross.
      if (f > longint'(max_hz)) f = longint'(max_hz);
      if (f < longint'(min_hz)) f = longint'(min_hz);
      tone_hz = f[15:0];
    end else if (full_scale == '0) begin
      tone_hz = max_hz;
    end else begin
      // Signed span: crossed limits scale downwards, truncating toward zero.
      span = longint'(max_hz) - longint'(min_hz);
      tone_hz = clip16(longint'(min_hz) + (longint'(smp) * span) / longint'(full_scale));
    end
    r.freq = tone_hz;
    r.div  = timer_compare(tone_hz);
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      min_hz     = MIN_FREQ_RST;
      max_hz     = MAX_FREQ_RST;
      step_hz    = STEP_SIZE_RST;
      timer_clk  = TIMER_CLOCK_RST;
      full_scale = ADC_FULL_SCALE_RST;
      tone_hz    = TONE_FREQ_RST;
      expected_tones.delete();
    end else begin
      if (out_valid && !out_stall) begin
        got = {out_frequency, out_divider, out_echo_valid, out_echo_byte};
        if (expected_tones.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected result freq %0d div %0d echo %0b byte %02h", $time,
                     got.freq, got.div, got.echo_v, got.echo_b);
        end else begin
          want = expected_tones.pop_front();
          if (got.freq !== want.freq || got.div !== want.div ||
              got.echo_v !== want.echo_v || got.echo_b !== want.echo_b) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: mismatch freq %0d/%0d div %0d/%0d echo %0b/%0b byte %02h/%02h",
                       $time, want.freq, got.freq, want.div, got.div,
                       want.echo_v, got.echo_v, want.echo_b, got.echo_b);
          end
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_MIN_FREQ:       min_hz     = cfg_wdata[15:0];
          REG_MAX_FREQ:       max_hz     = cfg_wdata[15:0];
          REG_STEP_SIZE:      step_hz    = cfg_wdata[7:0];
          REG_TIMER_CLOCK:    timer_clk  = cfg_wdata[23:0];
          REG_ADC_FULL_SCALE: full_scale = cfg_wdata[ADC_BITS_DEF-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall)
        expected_tones.push_back(advance_tone(in_action, in_received_byte, in_adc_sample));
    end
    fail_count <= mismatches;
    pending    <= expected_tones.size();
  end

endmodule

// ===== test/tb_top.sv =====
// Top of the tone divider control testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module tb_top;
  import tdc_pkg::*;

  localparam logic [CFG_INDEX_W-1:0] REG_SPARE = 3'd7;
  localparam int RANDOM_PHASES   = 10;
  localparam int ITEMS_PER_PHASE = 165;

  logic                    clk = 1'b0;
  logic                    rst_n;
  logic                    cfg_we;
  logic [CFG_INDEX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0]   cfg_wdata;
  logic                    in_valid;
  logic                    in_stall;
  logic                    in_action;
  logic [7:0]              in_received_byte;
  logic [ADC_BITS_DEF-1:0] in_adc_sample;
  logic                    out_valid;
  logic                    out_stall;
  logic [15:0]             out_frequency;
  logic [15:0]             out_divider;
  logic                    out_echo_valid;
  logic [7:0]              out_echo_byte;

  int fail_count;
  int pending;
  bit quiet     = 1'b0;
  bit hold_req  = 1'b0;
  bit hold_done = 1'b0;

  always #1 clk = ~clk;

  tone_divider_control_core dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_action        (in_action),
    .in_received_byte (in_received_byte),
    .in_adc_sample    (in_adc_sample),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_frequency    (out_frequency),
    .out_divider      (out_divider),
    .out_echo_valid   (out_echo_valid),
    .out_echo_byte    (out_echo_byte)
  );

  tdc_result_checker u_check (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_action        (in_action),
    .in_received_byte (in_received_byte),
    .in_adc_sample    (in_adc_sample),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_frequency    (out_frequency),
    .out_divider      (out_divider),
    .out_echo_valid   (out_echo_valid),
    .out_echo_byte    (out_echo_byte),
    .fail_count       (fail_count),
    .pending          (pending)
  );

  initial begin
    #2000000;
    $display("tb: failure");
    $finish;
  end

  // Result side: random stall bursts, one long hold-off, and none in the quiet tail.
  initial begin
    out_stall <= 1'b0;
    @(posedge clk);
    wait (rst_n);
    forever begin
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        out_stall <= 1'b1;
        repeat (400) @(posedge clk);
      end else if (quiet || $urandom_range(0, 3) != 0) begin
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 24)) @(posedge clk);
      end else begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end
    end
  end

  task automatic send_item(input logic act, input logic [7:0] ch,
                           input logic [ADC_BITS_DEF-1:0] smp, input int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_action        <= act;
    in_received_byte <= ch;
    in_adc_sample    <= smp;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Stops offering and waits until every outstanding result has been taken.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (64) @(posedge clk);
  endtask

  // Writes all five registers and the spare index; unused upper data bits carry noise.
  task automatic program_regs(input logic [15:0] lo, input logic [15:0] hi,
                              input logic [7:0] step, input logic [23:0] timer,
                              input logic [ADC_BITS_DEF-1:0] fs);
    logic [23:0] noise;
    noise = 24'($urandom);
    cfg_we    <= 1'b1;
    cfg_index <= REG_MIN_FREQ;
    cfg_wdata <= {noise[7:0], lo};
    @(posedge clk);
    cfg_index <= REG_MAX_FREQ;
    cfg_wdata <= {noise[15:8], hi};
    @(posedge clk);
    cfg_index <= REG_STEP_SIZE;
    cfg_wdata <= {noise[23:8], step};
    @(posedge clk);
    cfg_index <= REG_TIMER_CLOCK;
    cfg_wdata <= timer;
    @(posedge clk);
    cfg_index <= REG_ADC_FULL_SCALE;
    cfg_wdata <= {noise[13:0], fs};
    @(posedge clk);
    cfg_index <= REG_SPARE;
    cfg_wdata <= noise;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [15:0] pick_freq();
    case ($urandom_range(0, 7))
      0:       return 16'd0;
      1:       return 16'hFFFF;
      2:       return 16'd1;
      3, 4:    return 16'($urandom_range(20, 2000));
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  task automatic program_random();
    logic [15:0]             lo;
    logic [15:0]             hi;
    logic [15:0]             t;
    logic [7:0]              step;
    logic [23:0]             timer;
    logic [ADC_BITS_DEF-1:0] fs;
    lo = pick_freq();
    hi = pick_freq();
    // Mostly ordered limits; crossed ones now and then.
    if ($urandom_range(0, 4) != 0 && lo > hi) begin
      t  = lo;
      lo = hi;
      hi = t;
    end
    case ($urandom_range(0, 3))
      0:       step = 8'd0;
      1:       step = 8'hFF;
      default: step = 8'($urandom_range(0, 255));
    endcase
    case ($urandom_range(0, 6))
      0:       timer = 24'd1;
      1:       timer = 24'hFFFFFF;
      2:       timer = 24'd0;
      3, 4:    timer = 24'($urandom_range(1000, 2000000));
      default: timer = 24'($urandom);
    endcase
    case ($urandom_range(0, 5))
      0:       fs = '0;
      1:       fs = '1;
      2:       fs = 10'd1;
      default: fs = 10'($urandom_range(0, 1023));
    endcase
    program_regs(lo, hi, step, timer, fs);
  endtask

  // Terminal bytes lean towards plus and minus so the frequency moves about.
  task automatic random_item(output logic act, output logic [7:0] ch,
                             output logic [ADC_BITS_DEF-1:0] smp);
    act = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 9))
      0, 1, 2, 3: ch = CHAR_PLUS;
      4, 5, 6:    ch = CHAR_MINUS;
      7:          ch = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      default:    ch = 8'($urandom_range(0, 255));
    endcase
    case ($urandom_range(0, 7))
      0:       smp = '0;
      1:       smp = '1;
      default: smp = 10'($urandom_range(0, 1023));
    endcase
  endtask

  initial begin
    logic                    act;
    logic [7:0]              ch;
    logic [ADC_BITS_DEF-1:0] smp;
    int                      gap;
    bit                      sender_idles;
    rst_n            <= 1'b0;
    cfg_we           <= 1'b0;
    cfg_index        <= REG_MIN_FREQ;
    cfg_wdata        <= '0;
    in_valid         <= 1'b0;
    in_action        <= 1'b0;
    in_received_byte <= 8'd0;
    in_adc_sample    <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: both steps, ignored bytes, and samples at and between the ends.
    send_item(1'b0, CHAR_PLUS, '0, 0);
    send_item(1'b0, CHAR_MINUS, '0, 0);
    send_item(1'b0, 8'h00, '1, 0);
    send_item(1'b0, 8'hFF, '0, 0);
    send_item(1'b0, 8'h41, 10'h155, 0);
    send_item(1'b1, 8'h00, '0, 0);
    send_item(1'b1, CHAR_PLUS, '1, 0);
    send_item(1'b1, 8'hFF, 10'h155, 0);
    send_item(1'b1, 8'h00, 10'h2AA, 0);

    // Widest limits: steps saturate at both ends, and a zero frequency appears.
    drain_results();
    program_regs(16'd0, 16'hFFFF, 8'hFF, 24'hFFFFFF, 10'd1023);
    send_item(1'b1, 8'h00, '1, 0);
    send_item(1'b0, CHAR_PLUS, '0, 0);
    send_item(1'b1, 8'h00, '0, 0);
    send_item(1'b0, CHAR_MINUS, '0, 0);

    // Crossed limits with a tiny timer clock, so the divider bottoms out.
    drain_results();
    program_regs(16'd1000, 16'd50, 8'd0, 24'd1, 10'd1);
    send_item(1'b1, 8'h00, 10'd1, 0);
    send_item(1'b1, 8'h00, '1, 0);
    send_item(1'b0, 8'h78, '0, 0);
    send_item(1'b0, CHAR_PLUS, '0, 0);

    // Zero full scale takes the upper limit.
    drain_results();
    program_regs(16'd100, 16'd200, 8'd7, 24'd62500, 10'd0);
    send_item(1'b1, 8'h00, 10'd500, 0);
    send_item(1'b0, CHAR_MINUS, '0, 0);

    // Samples above full scale saturate.
    drain_results();
    program_regs(16'd0, 16'hFFFF, 8'd3, 24'd62500, 10'd1);
    send_item(1'b1, 8'h00, 10'd2, 0);
    send_item(1'b1, 8'h00, 10'd1, 0);
    send_item(1'b0, CHAR_MINUS, '0, 0);

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      drain_results();
      program_random();
      quiet        = (ph == RANDOM_PHASES - 1);
      sender_idles = (ph % 3 != 1) && !quiet;
      // The long hold-off falls in a phase where the sender never pauses.
      if (ph == 1) hold_req = 1'b1;
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        random_item(act, ch, smp);
        gap = (sender_idles && $urandom_range(0, 3) == 0) ? $urandom_range(1, 16) : 0;
        send_item(act, ch, smp, gap);
      end
    end

    drain_results();
    if (fail_count == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
